>>> design/fsrl_pkg.sv
// Shared constants for the failsafe slew-rate limiter.
package fsrl_pkg;

    // Position, command, timestamp and period widths.
    localparam int POS_W = 11;
    localparam int CMD_W = 16;
    localparam int TS_W = 32;
    localparam int PERIOD_W = 15;

    // Elapsed time is capped, so it fits in a narrow field.
    localparam int DT_W = 7;

    // Widest value of FULL_SCALE * dt + carry.
    localparam int NUMER_W = 18;

    // Divider iteration counter width.
    localparam int CNT_W = 5;

    localparam logic signed [POS_W-1:0] FULL_SCALE = 11'sd1000;
    localparam logic [NUMER_W-1:0] FULL_SCALE_U = 18'd1000;
    localparam logic [DT_W-1:0] MAX_TICK_MS = 7'd100;
    localparam logic [PERIOD_W-1:0] MIN_PERIOD_MS = 15'd100;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 15'd2000;

    localparam logic [CNT_W-1:0] DIV_LAST = 5'(NUMER_W - 1);

endpackage

>>> design/failsafe_slew_rate_limiter_top.sv
// Failsafe slew-rate limiter with a bit-serial restoring divider for the allowance.
// The result passes through the prepare, multiply, 18 divider steps and apply states to a
// registered m_tvalid; the divider loop resolves one quotient bit per cycle.
// A tick is taken only after the last one is applied; its result may wait while the next tick is accepted.
// Reset: rst_n is asynchronous, active low; the period returns to 2000 ms and the
// tick history, slew flag, carry and position clear to zero.
module failsafe_slew_rate_limiter_top
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: full_to_center_ms.
    input  logic        cfg_we,
    input  logic [14:0] cfg_wdata,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: now_ms [31:0], failsafe_engaged [32], commanded [48:33], zero fill.
    input  logic [55:0] s_tdata,
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: position_out [10:0], zero fill.
    output logic [15:0] m_tdata
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_APPLY
    } state_t;

    state_t state_reg, state_next;

    logic [fsrl_pkg::PERIOD_W-1:0] period_cfg_reg, period_cfg_next;
    logic                          have_prev_reg, have_prev_next;
    logic [fsrl_pkg::TS_W-1:0]     prev_tick_reg, prev_tick_next;
    logic                          slewing_reg, slewing_next;
    logic [fsrl_pkg::PERIOD_W-1:0] carry_reg, carry_next;
    logic signed [fsrl_pkg::POS_W-1:0] position_reg, position_next;

    logic [fsrl_pkg::TS_W-1:0]     now_reg, now_next;
    logic                          fs_reg, fs_next;
    logic signed [fsrl_pkg::POS_W-1:0] cmd_reg, cmd_next;
    logic [fsrl_pkg::DT_W-1:0]     dt_reg, dt_next;
    logic [fsrl_pkg::NUMER_W-1:0]  nq_reg, nq_next;
    logic [fsrl_pkg::PERIOD_W-1:0] rem_reg, rem_next;
    logic [fsrl_pkg::CNT_W-1:0]    cnt_reg, cnt_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [fsrl_pkg::POS_W-1:0]    m_data_reg, m_data_next;

    // Combinational helpers.
    logic signed [fsrl_pkg::CMD_W-1:0] in_cmd;
    logic signed [fsrl_pkg::POS_W-1:0] in_cmd_clamped;
    logic [fsrl_pkg::TS_W-1:0]     elapsed;
    logic [fsrl_pkg::PERIOD_W-1:0] period;
    logic [fsrl_pkg::PERIOD_W:0]   trial;
    logic [fsrl_pkg::PERIOD_W:0]   trial_diff;
    logic                          trial_fits;
    logic signed [fsrl_pkg::POS_W-1:0] target;
    logic signed [fsrl_pkg::POS_W:0]   distance;
    logic [fsrl_pkg::POS_W:0]      magnitude;
    logic signed [fsrl_pkg::POS_W-1:0] moved;
    logic                          out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, m_data_reg};

    // Clamp the incoming command to plus or minus full scale.
    assign in_cmd = s_tdata[48:33];
    always_comb
    begin
        if (in_cmd > fsrl_pkg::CMD_W'(fsrl_pkg::FULL_SCALE))
        begin
            in_cmd_clamped = fsrl_pkg::FULL_SCALE;
        end
        else if (in_cmd < -fsrl_pkg::CMD_W'(fsrl_pkg::FULL_SCALE))
        begin
            in_cmd_clamped = -fsrl_pkg::FULL_SCALE;
        end
        else
        begin
            in_cmd_clamped = in_cmd[fsrl_pkg::POS_W-1:0];
        end
    end

    // Wrapping elapsed time and the effective period.
    assign elapsed = now_reg - prev_tick_reg;
    assign period  = (period_cfg_reg == '0) ? fsrl_pkg::MIN_PERIOD_MS : period_cfg_reg;

    // One restoring division step: shift in the next numerator bit and try to subtract.
    assign trial      = {rem_reg, nq_reg[fsrl_pkg::NUMER_W-1]};
    assign trial_diff = trial - {1'b0, period};
    assign trial_fits = (trial >= {1'b0, period});

    // Move toward the target by the allowance, landing exactly when it covers the distance.
    assign target    = fs_reg ? '0 : cmd_reg;
    assign distance  = (fsrl_pkg::POS_W+1)'(target) - (fsrl_pkg::POS_W+1)'(position_reg);
    assign magnitude = distance[fsrl_pkg::POS_W] ? 12'(-distance) : 12'(distance);
    always_comb
    begin
        if (18'(magnitude) <= nq_reg)
        begin
            moved = target;
        end
        else if (distance[fsrl_pkg::POS_W])
        begin
            moved = position_reg - nq_reg[fsrl_pkg::POS_W-1:0];
        end
        else
        begin
            moved = position_reg + nq_reg[fsrl_pkg::POS_W-1:0];
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // Next-state logic for the sequencer and all registers.
    always_comb
    begin
        state_next      = state_reg;
        period_cfg_next = period_cfg_reg;
        have_prev_next  = have_prev_reg;
        prev_tick_next  = prev_tick_reg;
        slewing_next    = slewing_reg;
        carry_next      = carry_reg;
        position_next   = position_reg;
        now_next        = now_reg;
        fs_next         = fs_reg;
        cmd_next        = cmd_reg;
        dt_next         = dt_reg;
        nq_next         = nq_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_data_next     = m_data_reg;

        // The output register clears once its transaction completes.
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // A period write clears the carry; writes must arrive only while idle, which the block itself does not enforce.
        if (cfg_we)
        begin
            period_cfg_next = cfg_wdata;
            carry_next      = '0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    now_next   = s_tdata[31:0];
                    fs_next    = s_tdata[32];
                    cmd_next   = in_cmd_clamped;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                // Elapsed time, zero on the first tick and capped at the maximum tick.
                if (!have_prev_reg)
                begin
                    dt_next = '0;
                end
                else if (elapsed > 32'(fsrl_pkg::MAX_TICK_MS))
                begin
                    dt_next = fsrl_pkg::MAX_TICK_MS;
                end
                else
                begin
                    dt_next = elapsed[fsrl_pkg::DT_W-1:0];
                end
                have_prev_next = 1'b1;
                prev_tick_next = now_reg;
                // Engaging the failsafe starts a slew with a fresh carry.
                if (fs_reg && !slewing_reg)
                begin
                    slewing_next = 1'b1;
                    carry_next   = '0;
                end
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                nq_next    = 18'(dt_reg) * fsrl_pkg::FULL_SCALE_U + 18'(carry_reg);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = trial_fits ? trial_diff[fsrl_pkg::PERIOD_W-1:0]
                                      : trial[fsrl_pkg::PERIOD_W-1:0];
                nq_next  = {nq_reg[fsrl_pkg::NUMER_W-2:0], trial_fits};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == fsrl_pkg::DIV_LAST)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                // Wait until the output register can take the result.
                if (out_free)
                begin
                    if (slewing_reg)
                    begin
                        position_next = moved;
                        carry_next    = rem_reg;
                        // Release completes when the output reaches the live command.
                        if (!fs_reg && (moved == cmd_reg))
                        begin
                            slewing_next = 1'b0;
                            carry_next   = '0;
                        end
                        m_data_next = moved;
                    end
                    else
                    begin
                        position_next = cmd_reg;
                        m_data_next   = cmd_reg;
                    end
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            period_cfg_reg <= fsrl_pkg::PERIOD_RESET;
            have_prev_reg  <= 1'b0;
            prev_tick_reg  <= '0;
            slewing_reg    <= 1'b0;
            carry_reg      <= '0;
            position_reg   <= '0;
            now_reg        <= '0;
            fs_reg         <= 1'b0;
            cmd_reg        <= '0;
            dt_reg         <= '0;
            nq_reg         <= '0;
            rem_reg        <= '0;
            cnt_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
            m_data_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            period_cfg_reg <= period_cfg_next;
            have_prev_reg  <= have_prev_next;
            prev_tick_reg  <= prev_tick_next;
            slewing_reg    <= slewing_next;
            carry_reg      <= carry_next;
            position_reg   <= position_next;
            now_reg        <= now_next;
            fs_reg         <= fs_next;
            cmd_reg        <= cmd_next;
            dt_reg         <= dt_next;
            nq_reg         <= nq_next;
            rem_reg        <= rem_next;
            cnt_reg        <= cnt_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_data_reg     <= m_data_next;
        end
    end

endmodule
